// ===== design/hfm_pkg.sv =====
// ----------------------------------------------------------------------------
// hfm_pkg
// Shared types, constants and helpers of the header field matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package hfm_pkg;

   // default number of pattern bytes, and the register file limit
   localparam int PATTERN_BYTES_DEF = 16;
   localparam int PAT_MAX_BYTES     = 16;
   localparam int PAT_IDX_W         = 4;

   // configuration port geometry
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = 3;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MATCH_MODE     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_EXACT_CASE     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_NEGATE         = 3'd5;

   // match modes
   localparam logic [1:0] MODE_WORD      = 2'd0;
   localparam logic [1:0] MODE_SUBSTRING = 2'd1;
   localparam logic [1:0] MODE_PREFIX    = 2'd2;
   localparam logic [1:0] MODE_PARAM     = 2'd3;

   // special characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5a;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   // configuration bundle
   typedef struct packed {
      logic [63:0] pattern_high;
      logic [63:0] pattern_low;
      logic [4:0]  pattern_length;
      logic [1:0]  match_mode;
      logic        exact_case;
      logic        negate;
   } hfm_cfg_type;

   // fold upper case ascii letters to lower case when enabled
   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_en);
      logic [7:0] r;
      r = c;
      if (fold_en && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         r = c | CASE_BIT;
      end
      return r;
   endfunction

   // one pattern byte, byte 0 in the low bits of pattern_low
   function automatic logic [7:0] pattern_byte(input hfm_cfg_type cfg,
                                               input logic [PAT_IDX_W-1:0] idx);
      logic [PAT_MAX_BYTES-1:0][7:0] bytes;
      bytes = {cfg.pattern_high, cfg.pattern_low};
      return bytes[idx];
   endfunction

endpackage

`default_nettype wire

// ===== design/hfm_if.sv =====
// ----------------------------------------------------------------------------
// hfm_if
// Valid/ready channels of the header field matcher: value bytes and verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

// value byte channel
interface hfm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] value_byte;
   logic       last;

   modport source(output valid, output value_byte, output last, input ready);
   modport sink(input valid, input value_byte, input last, output ready);
endinterface

// verdict channel
interface hfm_rsp_if;
   logic valid;
   logic ready;
   logic matched;

   modport source(output valid, output matched, input ready);
   modport sink(input valid, input matched, output ready);
endinterface

`default_nettype wire

// ===== design/header_field_matcher.sv =====
// ----------------------------------------------------------------------------
// header_field_matcher
// Splits a header value into comma-separated fields and matches each field
// against a programmed pattern in word, substring, prefix or parameter mode.
// ----------------------------------------------------------------------------
// One value byte is taken per cycle, back to back; a byte is accepted
// whenever the verdict register is empty or being drained in the same cycle.
// Each field byte passes through a row of PATTERN_BYTES window cells that compare
// the latest field bytes to the pattern in parallel, so substring matching
// needs no second pass. The verdict for a value is registered and appears
// on the result channel the cycle after its last byte is accepted. Program
// the pattern registers only while no value is in flight.
`default_nettype none

module header_field_matcher #(
   parameter int PATTERN_BYTES = hfm_pkg::PATTERN_BYTES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   hfm_req_if.sink                             req_port,
   hfm_rsp_if.source                           rsp_port,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [hfm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [hfm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [hfm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import hfm_pkg::*;

   localparam int POS_W = $clog2(PATTERN_BYTES + 2);

   hfm_cfg_type      cfg;
   logic [POS_W-1:0] eff_len;
   logic             accept;
   logic             shift_en;
   logic             window_eq;
   logic             matched;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_matched_ff, rsp_matched_in;

   // input handshake: free output slot or one being drained
   assign req_port.ready = ~rsp_valid_ff | rsp_port.ready;
   assign accept         = req_port.valid & req_port.ready;

   // pattern length clipped to the window size
   assign eff_len = (cfg.pattern_length > 5'(PATTERN_BYTES)) ?
                    POS_W'(PATTERN_BYTES) : POS_W'(cfg.pattern_length);

   hfm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hfm_window #(.PATTERN_BYTES(PATTERN_BYTES)) u_window (
      .clock     (clock),
      .shift_en  (shift_en),
      .in_byte   (req_port.value_byte),
      .cfg       (cfg),
      .eff_len   (eff_len),
      .window_eq (window_eq)
   );

   hfm_scan #(.PATTERN_BYTES(PATTERN_BYTES)) u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .value_byte (req_port.value_byte),
      .last       (req_port.last),
      .cfg        (cfg),
      .eff_len    (eff_len),
      .window_eq  (window_eq),
      .shift_en   (shift_en),
      .matched    (matched)
   );

   // verdict register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff & ~rsp_port.ready;
      rsp_matched_in = rsp_matched_ff;
      if (accept && req_port.last) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = matched;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.matched = rsp_matched_ff;

endmodule

`default_nettype wire

// ===== design/hfm_csr.sv =====
// ----------------------------------------------------------------------------
// hfm_csr
// APB-style register file holding the pattern and the match options.
// ----------------------------------------------------------------------------
`default_nettype none

module hfm_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [hfm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [hfm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [hfm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                              csr_pready,
   output hfm_pkg::hfm_cfg_type              cfg
);
   import hfm_pkg::*;

   hfm_cfg_type           cfg_ff;
   hfm_cfg_type           cfg_in;
   logic                  wr_en;
   logic [REG_IDX_W-1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_PATTERN_LOW:    cfg_in.pattern_low    = csr_pwdata;
            REG_PATTERN_HIGH:   cfg_in.pattern_high   = csr_pwdata;
            REG_PATTERN_LENGTH: cfg_in.pattern_length = csr_pwdata[4:0];
            REG_MATCH_MODE:     cfg_in.match_mode     = csr_pwdata[1:0];
            REG_EXACT_CASE:     cfg_in.exact_case     = csr_pwdata[0];
            REG_NEGATE:         cfg_in.negate         = csr_pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // read decode
   always_comb begin
      unique case (reg_idx)
         REG_PATTERN_LOW:    csr_prdata = cfg_ff.pattern_low;
         REG_PATTERN_HIGH:   csr_prdata = cfg_ff.pattern_high;
         REG_PATTERN_LENGTH: csr_prdata = CSR_DATA_W'(cfg_ff.pattern_length);
         REG_MATCH_MODE:     csr_prdata = CSR_DATA_W'(cfg_ff.match_mode);
         REG_EXACT_CASE:     csr_prdata = CSR_DATA_W'(cfg_ff.exact_case);
         REG_NEGATE:         csr_prdata = CSR_DATA_W'(cfg_ff.negate);
         default:            csr_prdata = '0;
      endcase
   end

   // register storage
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low    <= '0;
         cfg_ff.pattern_high   <= '0;
         cfg_ff.pattern_length <= 5'd1;
         cfg_ff.match_mode     <= MODE_WORD;
         cfg_ff.exact_case     <= 1'b0;
         cfg_ff.negate         <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/hfm_cell.sv =====
// ----------------------------------------------------------------------------
// hfm_cell
// One window cell: holds one recent field byte and compares the byte moving
// into it against its pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hfm_cell (
   input  wire logic       clock,
   input  wire logic       shift_en,
   input  wire logic [7:0] in_byte,
   input  wire logic [7:0] ref_byte,
   input  wire logic       fold_en,
   output logic      [7:0] held_byte,
   output logic            hit
);
   import hfm_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // compare the incoming byte, which is what this cell holds after the shift
   assign hit       = (fold_byte(in_byte, fold_en) == fold_byte(ref_byte, fold_en));
   assign byte_in   = shift_en ? in_byte : byte_ff;
   assign held_byte = byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

`default_nettype wire

// ===== design/hfm_window.sv =====
// ----------------------------------------------------------------------------
// hfm_window
// Row of cells forming the sliding byte window; reports when the last
// pattern-length bytes of the field equal the pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module hfm_window #(
   parameter int PATTERN_BYTES = hfm_pkg::PATTERN_BYTES_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  shift_en,
   input  wire logic [7:0]                            in_byte,
   input  wire hfm_pkg::hfm_cfg_type                  cfg,
   input  wire logic [$clog2(PATTERN_BYTES+2)-1:0]    eff_len,
   output logic                                       window_eq
);
   import hfm_pkg::*;

   localparam int POS_W = $clog2(PATTERN_BYTES + 2);

   logic [PATTERN_BYTES-1:0][7:0] held;
   logic [PATTERN_BYTES-1:0]      hits;
   logic [PATTERN_BYTES-1:0]      use_mask;

   // cell j holds the byte j places back and checks pattern byte len-1-j
   for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_cell
      logic [7:0]           cell_in;
      logic [PAT_IDX_W-1:0] ref_idx;

      if (j == 0) begin : g_head
         assign cell_in = in_byte;
      end else begin : g_link
         assign cell_in = held[j-1];
      end

      assign ref_idx     = PAT_IDX_W'(eff_len - POS_W'(j + 1));
      assign use_mask[j] = (POS_W'(j) < eff_len);

      hfm_cell u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .in_byte   (cell_in),
         .ref_byte  (pattern_byte(cfg, ref_idx)),
         .fold_en   (~cfg.exact_case),
         .held_byte (held[j]),
         .hit       (hits[j])
      );
   end

   // cells beyond the pattern length do not take part
   assign window_eq = &(hits | ~use_mask);

endmodule

`default_nettype wire

// ===== design/hfm_scan.sv =====
// ----------------------------------------------------------------------------
// hfm_scan
// Field splitter and per-field match tracking; gives the verdict on the
// last byte of a value.
// ----------------------------------------------------------------------------
`default_nettype none

module hfm_scan #(
   parameter int PATTERN_BYTES = hfm_pkg::PATTERN_BYTES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire logic [7:0]                         value_byte,
   input  wire logic                               last,
   input  wire hfm_pkg::hfm_cfg_type               cfg,
   input  wire logic [$clog2(PATTERN_BYTES+2)-1:0] eff_len,
   input  wire logic                               window_eq,
   output logic                                    shift_en,
   output logic                                    matched
);
   import hfm_pkg::*;

   localparam int POS_W = $clog2(PATTERN_BYTES + 2);
   localparam logic [POS_W-1:0] POS_CAP = POS_W'(PATTERN_BYTES + 1);

   // scan phases
   localparam logic [1:0] PH_BETWEEN = 2'd0;
   localparam logic [1:0] PH_FIELD   = 2'd1;
   localparam logic [1:0] PH_QUOTE   = 2'd2;
   localparam logic [1:0] PH_ESCAPE  = 2'd3;

   // parameter-prefix tracking
   localparam logic [1:0] PP_PENDING = 2'd0;
   localparam logic [1:0] PP_SPACES  = 2'd1;
   localparam logic [1:0] PP_HIT     = 2'd2;
   localparam logic [1:0] PP_MISS    = 2'd3;

   logic [1:0]       phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] tlen_ff, tlen_in;
   logic             peq_ff, peq_in;
   logic             subp_ff, subp_in;
   logic [1:0]       pp_ff, pp_in;
   logic             found_ff, found_in;
   logic             term_ff, term_in;

   logic             fb;
   logic             start;
   logic             end_mid;
   logic             end_now;
   logic             hit;
   logic             fold_en;
   logic             not_space;
   logic [1:0]       phase_a;
   logic [POS_W-1:0] pos0, pos1, tlen0, tlen1;
   logic             peq0, peq1, subp0, subp1;
   logic [1:0]       pp0, pp1;
   logic             found1, found2;

   assign fold_en   = ~cfg.exact_case;
   assign not_space = (value_byte != CH_SPACE);
   assign shift_en  = accept & fb;

   // splitter: decides whether the byte belongs to a field
   always_comb begin
      phase_a = phase_ff;
      term_in = term_ff;
      fb      = 1'b0;
      start   = 1'b0;
      end_mid = 1'b0;
      if (!term_ff) begin
         if (value_byte == CH_NUL) begin
            end_mid = (phase_ff != PH_BETWEEN);
            term_in = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_BETWEEN: begin
                  if (value_byte != CH_SPACE && value_byte != CH_COMMA) begin
                     start   = 1'b1;
                     fb      = 1'b1;
                     phase_a = (value_byte == CH_QUOTE) ? PH_QUOTE : PH_FIELD;
                  end
               end
               PH_FIELD: begin
                  if (value_byte == CH_COMMA) begin
                     end_mid = 1'b1;
                  end else begin
                     fb = 1'b1;
                     if (value_byte == CH_QUOTE) begin
                        phase_a = PH_QUOTE;
                     end
                  end
               end
               PH_QUOTE: begin
                  fb = 1'b1;
                  if (value_byte == CH_BSLASH) begin
                     phase_a = PH_ESCAPE;
                  end else if (value_byte == CH_QUOTE) begin
                     phase_a = PH_FIELD;
                  end
               end
               default: begin
                  fb      = 1'b1;
                  phase_a = PH_QUOTE;
               end
            endcase
         end
      end
   end

   // field state at the start of the byte
   always_comb begin
      pos0  = start ? '0 : pos_ff;
      tlen0 = start ? '0 : tlen_ff;
      peq0  = start ? 1'b1 : peq_ff;
      subp0 = start ? 1'b0 : subp_ff;
      if (start) begin
         pp0 = (eff_len == '0) ? PP_SPACES : PP_PENDING;
      end else begin
         pp0 = pp_ff;
      end
   end

   // per-byte update of the field trackers
   always_comb begin
      peq1   = peq0;
      pp1    = pp0;
      subp1  = subp0;
      found1 = found_ff;
      if (pos0 < eff_len) begin
         if (fold_byte(value_byte, fold_en) !=
             fold_byte(pattern_byte(cfg, PAT_IDX_W'(pos0)), fold_en)) begin
            peq1 = 1'b0;
         end
      end else if (pp0 == PP_SPACES) begin
         if (value_byte == CH_SEMI) begin
            pp1 = PP_HIT;
         end else if (not_space) begin
            pp1 = PP_MISS;
         end
      end
      pos1 = (pos0 < POS_CAP) ? pos0 + 1'b1 : POS_CAP;
      if (pos1 == eff_len && pp1 == PP_PENDING) begin
         pp1 = peq1 ? PP_SPACES : PP_MISS;
      end
      tlen1 = not_space ? pos1 : tlen0;
      if (cfg.match_mode == MODE_SUBSTRING) begin
         if (not_space && subp0) begin
            found1 = 1'b1;
         end
         if (pos1 >= eff_len && window_eq) begin
            if (not_space) begin
               found1 = 1'b1;
            end else begin
               subp1 = 1'b1;
            end
         end
      end
      if (!fb) begin
         pos1   = pos_ff;
         tlen1  = tlen_ff;
         peq1   = peq_ff;
         pp1    = pp_ff;
         subp1  = subp_ff;
         found1 = found_ff;
      end
   end

   // field end and verdict
   always_comb begin
      end_now = end_mid | (last & ~term_in & (phase_a != PH_BETWEEN));
      unique case (cfg.match_mode)
         MODE_WORD:   hit = (tlen1 == eff_len) & peq1;
         MODE_PREFIX: hit = (tlen1 >= eff_len) & peq1;
         MODE_PARAM:  hit = ((pp1 == PP_SPACES) || (pp1 == PP_HIT)) && (tlen1 >= eff_len);
         default:     hit = 1'b0;
      endcase
      found2  = found1 | (end_now & hit);
      matched = found2 ^ cfg.negate;

      phase_in = end_now ? PH_BETWEEN : phase_a;
      subp_in  = end_now ? 1'b0 : subp1;
      pos_in   = pos1;
      tlen_in  = tlen1;
      peq_in   = peq1;
      pp_in    = pp1;
      found_in = found2;
      // the last byte closes the value
      if (last) begin
         phase_in = PH_BETWEEN;
         pos_in   = '0;
         tlen_in  = '0;
         peq_in   = 1'b1;
         subp_in  = 1'b0;
         pp_in    = PP_PENDING;
         found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BETWEEN;
         pos_ff   <= '0;
         tlen_ff  <= '0;
         peq_ff   <= 1'b1;
         subp_ff  <= 1'b0;
         pp_ff    <= PP_PENDING;
         found_ff <= 1'b0;
         term_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         tlen_ff  <= tlen_in;
         peq_ff   <= peq_in;
         subp_ff  <= subp_in;
         pp_ff    <= pp_in;
         found_ff <= found_in;
         term_ff  <= last ? 1'b0 : term_in;
      end
   end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the header field matcher. Header values are fed
// byte by byte on the request channel while a behavioral copy of the field
// splitter and pattern compare predicts the verdict of each value. Verdicts
// are checked in order on the response channel. Directed values cover every
// match mode, the corner cases and one long response stall that backs up
// the input, then random register settings drive mostly well-formed field
// lists with random gaps on both sides.
// ----------------------------------------------------------------------------

module tb_top;
   import hfm_pkg::*;

   localparam int WINDOW  = PATTERN_BYTES_DEF;
   localparam int POS_CAP = WINDOW + 1;

   typedef logic [7:0] octet_queue_type[$];
   typedef enum logic [1:0] {
      SCAN_BETWEEN, SCAN_FIELD, SCAN_INQUOTE, SCAN_ESCAPE
   } scan_phase_type;
   typedef enum logic [1:0] {
      PARAM_PENDING, PARAM_SPACES, PARAM_HIT, PARAM_MISS
   } param_phase_type;

   logic clock = 1'b0;
   logic reset;

   hfm_req_if req_ch();
   hfm_rsp_if rsp_ch();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   header_field_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_ch),
      .rsp_port   (rsp_ch),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // register copies used by the predictor
   logic [63:0] cfg_low  = '0;
   logic [63:0] cfg_high = '0;
   logic [4:0]  cfg_len  = 5'd1;
   logic [1:0]  cfg_mode = MODE_WORD;
   logic        cfg_case = 1'b0;
   logic        cfg_neg  = 1'b0;

   // scanner state
   scan_phase_type  scan_st    = SCAN_BETWEEN;
   param_phase_type param_st   = PARAM_PENDING;
   logic [4:0]   field_pos  = '0;
   logic [4:0]   trim_len   = '0;
   logic         prefix_eq  = 1'b1;
   logic         sub_pending = 1'b0;
   logic         found_any  = 1'b0;
   logic         terminated = 1'b0;
   logic [7:0]   window_q [WINDOW] = '{default: 8'h00};

   // expected verdicts, oldest first
   logic verdict_q[$];

   // bench controls and statistics
   bit send_gaps   = 1'b1;
   bit take_gaps   = 1'b1;
   int hold_cycles = 0;
   int errors      = 0;
   int bytes_sent  = 0;
   int values_sent = 0;
   int verdicts_checked = 0;
   int verdicts_matched = 0;
   int settings_used    = 0;

   // ---------------------------------------------------------------- predictor

   function automatic int pat_len_eff();
      return (cfg_len > WINDOW) ? WINDOW : int'(cfg_len);
   endfunction

   function automatic logic [7:0] pat_byte(input int i);
      return (i < 8) ? cfg_low[8*i +: 8] : cfg_high[8*(i-8) +: 8];
   endfunction

   function automatic logic [7:0] case_fold(input logic [7:0] c);
      if (!cfg_case && c >= CH_UPPER_A && c <= CH_UPPER_Z)
         return c + 8'd32;
      return c;
   endfunction

   function automatic void open_field();
      field_pos   = '0;
      trim_len    = '0;
      prefix_eq   = 1'b1;
      sub_pending = 1'b0;
      param_st    = (pat_len_eff() == 0) ? PARAM_SPACES : PARAM_PENDING;
   endfunction

   // one byte that belongs to the current field
   function automatic void take_field_byte(input logic [7:0] c);
      int len;
      int pos;
      int k;
      bit eq;
      len = pat_len_eff();
      pos = field_pos;
      for (k = WINDOW - 1; k > 0; k--)
         window_q[k] = window_q[k-1];
      window_q[0] = c;

      if (pos < len) begin
         if (case_fold(c) != case_fold(pat_byte(pos)))
            prefix_eq = 1'b0;
      end else if (param_st == PARAM_SPACES) begin
         if (c == CH_SEMI)
            param_st = PARAM_HIT;
         else if (c != CH_SPACE)
            param_st = PARAM_MISS;
      end
      pos = (pos < POS_CAP) ? pos + 1 : POS_CAP;
      if (pos == len && param_st == PARAM_PENDING)
         param_st = prefix_eq ? PARAM_SPACES : PARAM_MISS;
      field_pos = pos[4:0];
      if (c != CH_SPACE)
         trim_len = pos[4:0];

      // sliding window compare, a trailing space defers the hit
      if (cfg_mode == MODE_SUBSTRING) begin
         if (c != CH_SPACE && sub_pending)
            found_any = 1'b1;
         if (pos >= len) begin
            eq = 1'b1;
            for (k = 0; k < len; k++)
               if (case_fold(window_q[len-1-k]) != case_fold(pat_byte(k)))
                  eq = 1'b0;
            if (eq) begin
               if (c != CH_SPACE)
                  found_any = 1'b1;
               else
                  sub_pending = 1'b1;
            end
         end
      end
   endfunction

   function automatic void close_field();
      int len;
      bit hit;
      len = pat_len_eff();
      hit = 1'b0;
      case (cfg_mode)
         MODE_WORD:   hit = (int'(trim_len) == len) && prefix_eq;
         MODE_PREFIX: hit = (int'(trim_len) >= len) && prefix_eq;
         MODE_PARAM:  hit = (param_st == PARAM_SPACES || param_st == PARAM_HIT) &&
                            (int'(trim_len) >= len);
         default:     hit = 1'b0;
      endcase
      if (hit)
         found_any = 1'b1;
      scan_st     = SCAN_BETWEEN;
      sub_pending = 1'b0;
   endfunction

   function automatic void clear_value();
      scan_st     = SCAN_BETWEEN;
      field_pos   = '0;
      trim_len    = '0;
      prefix_eq   = 1'b1;
      sub_pending = 1'b0;
      param_st    = PARAM_PENDING;
      found_any   = 1'b0;
      terminated  = 1'b0;
   endfunction

   // advance the scanner by one accepted byte; returns 1 when a verdict is due
   function automatic bit scan_byte(input logic [7:0] c, input logic is_last,
                                    output logic verdict);
      verdict = 1'b0;
      if (!terminated) begin
         if (c == CH_NUL) begin
            if (scan_st != SCAN_BETWEEN)
               close_field();
            terminated = 1'b1;
         end else begin
            case (scan_st)
               SCAN_BETWEEN: begin
                  if (c != CH_SPACE && c != CH_COMMA) begin
                     open_field();
                     scan_st = (c == CH_QUOTE) ? SCAN_INQUOTE : SCAN_FIELD;
                     take_field_byte(c);
                  end
               end
               SCAN_FIELD: begin
                  if (c == CH_COMMA) begin
                     close_field();
                  end else begin
                     if (c == CH_QUOTE)
                        scan_st = SCAN_INQUOTE;
                     take_field_byte(c);
                  end
               end
               SCAN_INQUOTE: begin
                  take_field_byte(c);
                  if (c == CH_BSLASH)
                     scan_st = SCAN_ESCAPE;
                  else if (c == CH_QUOTE)
                     scan_st = SCAN_FIELD;
               end
               default: begin
                  take_field_byte(c);
                  scan_st = SCAN_INQUOTE;
               end
            endcase
         end
      end
      if (!is_last)
         return 1'b0;
      if (!terminated && scan_st != SCAN_BETWEEN)
         close_field();
      verdict = found_any ^ cfg_neg;
      clear_value();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
   endtask

   // accepted items feed the predictor, accepted verdicts are compared
   always @(posedge clock) begin : watch
      logic want;
      logic fresh;
      if (reset == 1'b0) begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (verdict_q.size() == 0) begin
               report_mismatch($sformatf("verdict %0b with none pending", rsp_ch.matched));
            end else begin
               want = verdict_q.pop_front();
               verdicts_checked++;
               if (rsp_ch.matched !== want)
                  report_mismatch($sformatf("matched %0b, expected %0b",
                                            rsp_ch.matched, want));
            end
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            if (scan_byte(req_ch.value_byte, req_ch.last, fresh)) begin
               verdict_q.push_back(fresh);
               if (fresh)
                  verdicts_matched++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // response side: random stall per verdict, or one long hold on request
   initial begin : verdict_taker
      int stall;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = take_gaps ? $urandom_range(0, 7) : 0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         @(negedge clock);
      end
   end

   // one item; called at a falling edge, returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      int gap;
      gap = send_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.value_byte <= b;
      req_ch.last       <= is_last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_value(input octet_queue_type v);
      int i;
      for (i = 0; i < v.size(); i++)
         send_byte(v[i], i == v.size() - 1);
      values_sent++;
   endtask

   function automatic octet_queue_type text_bytes(input string s);
      octet_queue_type q;
      int i;
      for (i = 0; i < s.len(); i++)
         q.push_back(s[i]);
      return q;
   endfunction

   // drop valid, let all verdicts arrive and the pipeline settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // apb write: setup then access, register taken when pready is seen;
   // the select stays up so writes can follow one another
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      case (idx)
         REG_PATTERN_LOW:    cfg_low  = data;
         REG_PATTERN_HIGH:   cfg_high = data;
         REG_PATTERN_LENGTH: cfg_len  = data[4:0];
         REG_MATCH_MODE:     cfg_mode = data[1:0];
         REG_EXACT_CASE:     cfg_case = data[0];
         REG_NEGATE:         cfg_neg  = data[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] len, input logic [1:0] mode,
                             input logic cs, input logic neg);
      wait_idle();
      csr_write(REG_PATTERN_LOW, lo);
      csr_write(REG_PATTERN_HIGH, hi);
      csr_write(REG_PATTERN_LENGTH, 64'(len));
      csr_write(REG_MATCH_MODE, 64'(mode));
      csr_write(REG_EXACT_CASE, 64'(cs));
      csr_write(REG_NEGATE, 64'(neg));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      settings_used++;
   endtask

   // ---------------------------------------------------------------- generators

   // filler bytes biased toward the characters the splitter cares about
   function automatic logic [7:0] junk_byte();
      case ($urandom_range(0, 9))
         0:       return CH_SPACE;
         1:       return CH_COMMA;
         2:       return CH_SEMI;
         3:       return CH_QUOTE;
         4:       return CH_BSLASH;
         5:       return 8'($urandom_range(1, 255));
         6:       return 8'($urandom_range(8'h41, 8'h44));
         default: return 8'($urandom_range(8'h61, 8'h64));
      endcase
   endfunction

   // pattern in use, with some letters flipped in case
   function automatic octet_queue_type pattern_text();
      octet_queue_type t;
      logic [7:0] c;
      int i;
      for (i = 0; i < pat_len_eff(); i++) begin
         c = pat_byte(i);
         if ((c & ~CASE_BIT) >= CH_UPPER_A && (c & ~CASE_BIT) <= CH_UPPER_Z &&
             $urandom_range(0, 3) == 0)
            c = c ^ CASE_BIT;
         t.push_back(c);
      end
      return t;
   endfunction

   function automatic octet_queue_type make_field();
      octet_queue_type f;
      octet_queue_type p;
      int j;
      p = pattern_text();
      case ($urandom_range(0, 6))
         0: f = p;
         1: begin
            repeat ($urandom_range(0, 3)) f.push_back(junk_byte());
            foreach (p[j]) f.push_back(p[j]);
            repeat ($urandom_range(0, 3)) f.push_back(junk_byte());
         end
         2: begin
            foreach (p[j]) f.push_back(p[j]);
            repeat ($urandom_range(0, 2)) f.push_back(CH_SPACE);
            if ($urandom_range(0, 3) != 0)
               f.push_back(CH_SEMI);
            repeat ($urandom_range(0, 4)) f.push_back(junk_byte());
         end
         3: begin
            foreach (p[j]) f.push_back(p[j]);
            repeat ($urandom_range(1, 4)) f.push_back(junk_byte());
         end
         4: begin
            f.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 3)) begin
               if ($urandom_range(0, 2) == 0)
                  f.push_back(CH_BSLASH);
               f.push_back(junk_byte());
            end
            foreach (p[j]) f.push_back(p[j]);
            if ($urandom_range(0, 3) != 0)
               f.push_back(CH_QUOTE);
         end
         5: begin
            for (j = 0; j + 1 < p.size(); j++)
               f.push_back(p[j]);
         end
         default: begin
            repeat ($urandom_range(1, 6)) f.push_back(8'($urandom_range(1, 255)));
         end
      endcase
      return f;
   endfunction

   // a header value: mostly a field list, sometimes noise or an early end
   function automatic octet_queue_type make_value();
      octet_queue_type v;
      octet_queue_type f;
      int i;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) v.push_back(8'($urandom_range(0, 255)));
         return v;
      end
      repeat ($urandom_range(0, 2))
         v.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_COMMA);
      for (i = 0; i < $urandom_range(0, 3); i++) begin
         if (i > 0) begin
            repeat ($urandom_range(0, 1)) v.push_back(CH_SPACE);
            v.push_back(CH_COMMA);
            repeat ($urandom_range(0, 2)) v.push_back(CH_SPACE);
         end
         f = make_field();
         foreach (f[j]) v.push_back(f[j]);
         repeat ($urandom_range(0, 2)) v.push_back(CH_SPACE);
      end
      if ($urandom_range(0, 9) == 0) begin
         v.push_back(CH_NUL);
         repeat ($urandom_range(0, 4)) v.push_back(junk_byte());
      end
      if (v.size() == 0)
         v.push_back(CH_SPACE);
      return v;
   endfunction

   function automatic logic [7:0] pattern_byte_pick();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 8'($urandom_range(8'h61, 8'h64));
         4, 5, 6:    return 8'($urandom_range(8'h41, 8'h44));
         7:          return CH_SPACE;
         8:          return CH_SEMI;
         default:    return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic random_config();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  len;
      int i;
      for (i = 0; i < 8; i++) begin
         lo[8*i +: 8] = pattern_byte_pick();
         hi[8*i +: 8] = pattern_byte_pick();
      end
      case ($urandom_range(0, 19))
         0:       len = 5'd0;
         1:       len = 5'($urandom_range(17, 31));
         2:       len = 5'd16;
         3, 4:    len = 5'($urandom_range(5, 15));
         default: len = 5'($urandom_range(1, 4));
      endcase
      set_config(lo, hi, len, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
   endtask

   // ---------------------------------------------------------------- tests

   // whole-word match, empty value, quoted field ending in a backslash
   task automatic test_word_mode();
      set_config(64'h6261, 64'h0, 5'd2, MODE_WORD, 1'b0, 1'b0);
      send_value(text_bytes("AB"));
      send_value(text_bytes(" , "));
      set_config(64'h5c22, 64'h0, 5'd2, MODE_WORD, 1'b0, 1'b0);
      send_value(text_bytes("\"\\"));
   endtask

   // substring inside a quote, all-ones pattern with oversized length
   task automatic test_substring_mode();
      octet_queue_type v;
      set_config(64'h6261, 64'h0, 5'd2, MODE_SUBSTRING, 1'b0, 1'b1);
      send_value(text_bytes("x\"aB"));
      set_config('1, '1, 5'd31, MODE_SUBSTRING, 1'b1, 1'b1);
      v = text_bytes("xx");
      v[0] = 8'hff;
      v[1] = 8'hff;
      send_value(v);
   endtask

   // prefix with exact case compare
   task automatic test_prefix_mode();
      set_config(64'h6261, 64'h0, 5'd2, MODE_PREFIX, 1'b1, 1'b0);
      send_value(text_bytes("Abc"));
      send_value(text_bytes("abc"));
   endtask

   // parameter prefix, and the empty pattern that needs a leading semicolon
   task automatic test_param_mode();
      set_config(64'h6261, 64'h0, 5'd2, MODE_PARAM, 1'b0, 1'b0);
      send_value(text_bytes("ab ;q"));
      set_config(64'h6261, 64'h0, 5'd0, MODE_PARAM, 1'b0, 1'b0);
      send_value(text_bytes(";x"));
   endtask

   // zero byte in the pattern, bytes after a zero byte, zero as the last byte
   task automatic test_special_cases();
      octet_queue_type v;
      set_config(64'h0061, 64'h0, 5'd2, MODE_WORD, 1'b0, 1'b1);
      v = text_bytes("xaab");
      v[0] = 8'h61;
      v[1] = CH_NUL;
      send_value(v);
      v = text_bytes("x");
      v[0] = CH_NUL;
      send_value(v);
   endtask

   // long response stall while values keep coming
   task automatic test_output_backpressure();
      set_config(64'h6261, 64'h0, 5'd2, MODE_WORD, 1'b0, 1'b0);
      send_gaps   = 1'b0;
      take_gaps   = 1'b0;
      hold_cycles = 150;
      repeat (30) send_value(text_bytes("ab"));
      wait_idle();
      send_gaps = 1'b1;
      take_gaps = 1'b1;
   endtask

   // random settings, each carrying a batch of generated values
   task automatic test_random_traffic();
      int phase;
      int goal;
      for (phase = 0; phase < 16; phase++) begin
         random_config();
         send_gaps = ($urandom_range(0, 3) != 0);
         take_gaps = ($urandom_range(0, 3) != 0);
         goal = bytes_sent + 100;
         while (bytes_sent < goal)
            send_value(make_value());
      end
      send_gaps = 1'b1;
      take_gaps = 1'b1;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.value_byte = 8'h00;
      req_ch.last       = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_word_mode();
      test_substring_mode();
      test_prefix_mode();
      test_param_mode();
      test_special_cases();
      test_output_backpressure();
      test_random_traffic();

      wait_idle();
      repeat (10) @(negedge clock);
      $display("covered %0d header values (%0d bytes) over %0d register settings",
               values_sent, bytes_sent, settings_used);
      $display("%0d verdicts checked, %0d expected to match, %0d mismatches",
               verdicts_checked, verdicts_matched, errors);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("timeout with %0d verdicts still pending", verdict_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
design/hfm_pkg.sv
design/hfm_if.sv
design/hfm_csr.sv
design/hfm_cell.sv
design/hfm_window.sv
design/hfm_scan.sv
design/header_field_matcher.sv
verif/tb_top.sv
